### sv/ilb_pkg.sv
// ----------------------------------------------------------------------------
// ilb_pkg: shared types and constants of the indexed list buffer
// Capacity, derived widths, command and status codes, cell operations and
// the decoded-command bundle passed from the decoder to the top level.
// ----------------------------------------------------------------------------
package ilb_pkg;

  localparam int CAPACITY      = 16;
  localparam int POS_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int CMD_W         = 3;
  localparam int INDEX_W       = 8;
  localparam int DATA_W        = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;
  localparam int CMP_W         = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [DATA_W-1:0] NO_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_FRONT  = 3'd1,
    CMD_BACK   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd_hit;
    logic [POS_W-1:0] pos;
    status_e          status;
    logic [CNT_W-1:0] cnt_next;
  } dec_t;

endpackage

### sv/indexed_list_buffer.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer: ordered list of signed 32-bit entries
// Row of storage cells with a held count; reads, inserts and deletes by
// position, shifting the whole row together.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command per transfer:
//   cmd_i, index_i and value_i. Output channel (out_valid_o / out_ready_i)
//   returns exactly one result per command: read_value_o, status_o and
//   entry_count_o (entries held after the command).
//   The result is registered and shows in the cycle after the input
//   transfer. Throughput: one command per cycle while the receiver takes
//   results; every cell decides its next entry from the broadcast command
//   in the same cycle, so the whole row shifts together.
//   The single output register frees in the cycle it is taken, so a new
//   command is accepted while a finished result is being transferred. When
//   the receiver stalls, in_ready_o drops and the held result stays put.
//   Reset clears the held count and the output valid; cell contents are
//   left as they are, since only counted entries are ever read.
// ----------------------------------------------------------------------------
module indexed_list_buffer import ilb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         cmd_i,
  input  logic [INDEX_W-1:0]       index_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [ENTRY_COUNT_W-1:0] entry_count_o
);

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   rd_value_q, rd_value_d;
  logic [STATUS_W-1:0] status_q;
  logic [CNT_W-1:0]    out_cnt_q;

  logic        accept;
  dec_t        dec;
  cell_op_e    cell_op   [CAPACITY];
  logic [DATA_W-1:0] cell_data [CAPACITY];

  // Accept when the output register is empty or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ilb_decode u_decode (
    .cmd_i   (cmd_i),
    .index_i (index_i),
    .count_i (cnt_q),
    .dec_o   (dec)
  );

  // Row of cells: each one looks at the broadcast position and its own place.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_data;
    logic [DATA_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = value_i;
    end else begin : g_mid_lo
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      // top cell drops out of the counted range on delete; hold it
      assign next_data = cell_data[i];
    end else begin : g_mid_hi
      assign next_data = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (accept && dec.ins) begin
        if (POS_W'(i) == dec.pos)     cell_op[i] = CELL_LOAD;
        else if (POS_W'(i) > dec.pos) cell_op[i] = CELL_SHIFT_UP;
      end else if (accept && dec.del) begin
        if (POS_W'(i) >= dec.pos) cell_op[i] = CELL_SHIFT_DOWN;
      end
    end

    ilb_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .value_i (value_i),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (cell_data[i])
    );
  end

  // Read value comes straight from the selected cell; -1 otherwise.
  assign rd_value_d = dec.rd_hit ? cell_data[dec.pos] : NO_VALUE;

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (accept) begin
      cnt_d       = dec.cnt_next;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: load on transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_value_q <= rd_value_d;
      status_q   <= dec.status;
      out_cnt_q  <= dec.cnt_next;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_value_q;
  assign status_o      = status_q;
  assign entry_count_o = ENTRY_COUNT_W'(out_cnt_q);

endmodule

### sv/ilb_cell.sv
// ----------------------------------------------------------------------------
// ilb_cell: one storage cell of the list chain
// Holds one entry; loads a new value, takes its lower neighbor's entry on an
// insert or its upper neighbor's entry on a delete.
// ----------------------------------------------------------------------------
module ilb_cell import ilb_pkg::*; (
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    case (op_i)
      CELL_LOAD:       data_d = value_i;
      CELL_SHIFT_UP:   data_d = prev_i;
      CELL_SHIFT_DOWN: data_d = next_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### sv/ilb_decode.sv
// ----------------------------------------------------------------------------
// ilb_decode: command decoder
// Checks range and fullness against the held count, picks the position and
// the count after the command.
// ----------------------------------------------------------------------------
module ilb_decode import ilb_pkg::*; (
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [INDEX_W-1:0] index_i,
  input  logic [CNT_W-1:0]   count_i,
  output dec_t               dec_o
);

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;

  assign idx_ext = CMP_W'(index_i);
  assign cnt_ext = CMP_W'(count_i);
  assign full    = (count_i >= CNT_W'(CAPACITY));

  always_comb begin
    dec_o        = '0;
    dec_o.status = ST_DONE;
    dec_o.pos    = idx_ext[POS_W-1:0];
    case (cmd_e'(cmd_i))
      CMD_READ: begin
        if (idx_ext < cnt_ext) dec_o.rd_hit = 1'b1;
        else                   dec_o.status = ST_RANGE;
      end
      CMD_FRONT: begin
        dec_o.pos = '0;
        if (full) dec_o.status = ST_FULL;
        else      dec_o.ins    = 1'b1;
      end
      CMD_BACK: begin
        // count is below capacity whenever this position is used
        dec_o.pos = count_i[POS_W-1:0];
        if (full) dec_o.status = ST_FULL;
        else      dec_o.ins    = 1'b1;
      end
      CMD_INSERT: begin
        if (idx_ext > cnt_ext) dec_o.status = ST_RANGE;
        else if (full)         dec_o.status = ST_FULL;
        else                   dec_o.ins    = 1'b1;
      end
      CMD_DELETE: begin
        if (idx_ext >= cnt_ext) dec_o.status = ST_RANGE;
        else                    dec_o.del    = 1'b1;
      end
      default: ;
    endcase

    if (dec_o.ins)      dec_o.cnt_next = count_i + CNT_W'(1);
    else if (dec_o.del) dec_o.cnt_next = count_i - CNT_W'(1);
    else                dec_o.cnt_next = count_i;
  end

endmodule
